### design/fmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_pkg
// Types, codes and sizes shared by the mutex / condition variable manager.
// ----------------------------------------------------------------------------
package fmc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 3;
    localparam int WOKEN_W  = 5;

    localparam logic [FUNC_W-1:0] FN_LOCK    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TRYLOCK = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UNLOCK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CWAIT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SIGNAL  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_BCAST   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTOWNER = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BREAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                owner_valid;
        logic [ID_W-1:0]     owner_id;
        logic                handed_over;
        logic [WOKEN_W-1:0]  woken_count;
    } result_t;

endpackage

### design/fmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_if
// Valid/ready channels for requests and results of the lock manager.
// ----------------------------------------------------------------------------
interface fmc_req_if;
    logic                        valid;
    logic                        ready;
    logic [fmc_pkg::FUNC_W-1:0]  func;
    logic [fmc_pkg::ID_W-1:0]    requester;

    modport source (output valid, output func, output requester, input ready);
    modport sink   (input valid, input func, input requester, output ready);
endinterface

interface fmc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fmc_pkg::STATUS_W-1:0]  status;
    logic                          owner_valid;
    logic [fmc_pkg::ID_W-1:0]      owner_id;
    logic                          handed_over;
    logic [fmc_pkg::WOKEN_W-1:0]   woken_count;

    modport source (output valid, output status, output owner_valid, output owner_id,
                    output handed_over, output woken_count, input ready);
    modport sink   (input valid, input status, input owner_valid, input owner_id,
                    input handed_over, input woken_count, output ready);
endinterface

### design/fifo_mutex_condvar_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mutex_condvar_manager_top
// One mutex and one condition variable with FIFO wait queues held in RAM.
// ----------------------------------------------------------------------------
// channel | dir | word
// --------+-----+--------------------------------------------------------
// req     | in  | func, requester
// rsp     | out | status, owner_valid, owner_id, handed_over, woken_count
//
// An item passes through accept (queue heads are read from RAM at that edge)
// and execute. A broadcast wakes one waiter per execute step, passing through
// ST_BREAD between wakes for the read of the next condition queue head.
// Results sit in an output register; a stalled result holds the sequencer.
// Reset empties both queues through their counters; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module fifo_mutex_condvar_manager_top
(
    input  logic      clk,
    input  logic      rst_n,
    fmc_req_if.sink   req,
    fmc_rsp_if.source rsp
);

    localparam logic [fmc_pkg::CNT_W-1:0] DEPTH_CNT = fmc_pkg::CNT_W'(fmc_pkg::QUEUE_DEPTH);
    localparam logic [fmc_pkg::PTR_W-1:0] LAST_PTR  = fmc_pkg::PTR_W'(fmc_pkg::QUEUE_DEPTH - 1);

    function automatic logic [fmc_pkg::PTR_W-1:0] ptr_inc(input logic [fmc_pkg::PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : fmc_pkg::PTR_W'(p + 1'b1);
    endfunction

    // queue storage
    logic [fmc_pkg::ID_W-1:0] lock_mem [fmc_pkg::QUEUE_DEPTH];
    logic [fmc_pkg::ID_W-1:0] cond_mem [fmc_pkg::QUEUE_DEPTH];
    logic [fmc_pkg::ID_W-1:0] lock_rdata_reg;
    logic [fmc_pkg::ID_W-1:0] cond_rdata_reg;
    logic                     lock_we;
    logic                     cond_we;
    logic [fmc_pkg::ID_W-1:0] lock_wdata;

    fmc_pkg::state_t            state_reg, state_next;
    logic                       held_reg, held_next;
    logic [fmc_pkg::ID_W-1:0]   holder_reg, holder_next;
    logic [fmc_pkg::PTR_W-1:0]  lock_head_reg, lock_head_next;
    logic [fmc_pkg::PTR_W-1:0]  lock_tail_reg, lock_tail_next;
    logic [fmc_pkg::CNT_W-1:0]  lock_cnt_reg, lock_cnt_next;
    logic [fmc_pkg::PTR_W-1:0]  cond_head_reg, cond_head_next;
    logic [fmc_pkg::PTR_W-1:0]  cond_tail_reg, cond_tail_next;
    logic [fmc_pkg::CNT_W-1:0]  cond_cnt_reg, cond_cnt_next;
    logic [fmc_pkg::WOKEN_W-1:0] woken_reg, woken_next;
    logic                       out_valid_reg, out_valid_next;

    logic [fmc_pkg::FUNC_W-1:0] func_reg;
    logic [fmc_pkg::ID_W-1:0]   req_id_reg;
    fmc_pkg::result_t           res_reg, res_next;
    fmc_pkg::result_t           out_reg, out_next;

    logic accept;
    logic out_free;
    logic owner;
    logic wake_ok;
    logic finish;
    logic [fmc_pkg::STATUS_W-1:0] status_c;
    logic                         handed_c;
    logic [fmc_pkg::WOKEN_W-1:0]  woken_c;

    assign req.ready = (state_reg == fmc_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.owner_valid = out_reg.owner_valid;
    assign rsp.owner_id    = out_reg.owner_id;
    assign rsp.handed_over = out_reg.handed_over;
    assign rsp.woken_count = out_reg.woken_count;

    assign owner   = held_reg && (holder_reg == req_id_reg);
    // head condition waiter can proceed unless it must join a full lock queue
    assign wake_ok = !held_reg || (holder_reg == cond_rdata_reg) || (lock_cnt_reg != DEPTH_CNT);

    always_ff @(posedge clk)
    begin
        if (lock_we)
        begin
            lock_mem[lock_tail_reg] <= lock_wdata;
        end
        if (cond_we)
        begin
            cond_mem[cond_tail_reg] <= req_id_reg;
        end
        lock_rdata_reg <= lock_mem[lock_head_reg];
        cond_rdata_reg <= cond_mem[cond_head_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        holder_next    = holder_reg;
        lock_head_next = lock_head_reg;
        lock_tail_next = lock_tail_reg;
        lock_cnt_next  = lock_cnt_reg;
        cond_head_next = cond_head_reg;
        cond_tail_next = cond_tail_reg;
        cond_cnt_next  = cond_cnt_reg;
        woken_next     = woken_reg;
        lock_we        = 1'b0;
        cond_we        = 1'b0;
        lock_wdata     = req_id_reg;
        finish         = 1'b0;
        status_c       = fmc_pkg::STAT_OK;
        handed_c       = 1'b0;
        woken_c        = '0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            fmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    woken_next = '0;
                    state_next = fmc_pkg::ST_EXEC;
                end
            end

            fmc_pkg::ST_EXEC:
            begin
                finish = 1'b1;
                unique case (func_reg)
                    fmc_pkg::FN_LOCK, fmc_pkg::FN_TRYLOCK:
                    begin
                        if (!held_reg)
                        begin
                            held_next   = 1'b1;
                            holder_next = req_id_reg;
                        end
                        else if (!owner)
                        begin
                            if (func_reg == fmc_pkg::FN_TRYLOCK)
                            begin
                                status_c = fmc_pkg::STAT_BUSY;
                            end
                            else if (lock_cnt_reg == DEPTH_CNT)
                            begin
                                status_c = fmc_pkg::STAT_FULL;
                            end
                            else
                            begin
                                lock_we        = 1'b1;
                                lock_tail_next = ptr_inc(lock_tail_reg);
                                lock_cnt_next  = fmc_pkg::CNT_W'(lock_cnt_reg + 1'b1);
                                status_c       = fmc_pkg::STAT_QUEUED;
                            end
                        end
                    end

                    fmc_pkg::FN_UNLOCK, fmc_pkg::FN_CWAIT:
                    begin
                        if (!owner)
                        begin
                            status_c = fmc_pkg::STAT_NOTOWNER;
                        end
                        else if ((func_reg == fmc_pkg::FN_CWAIT) && (cond_cnt_reg == DEPTH_CNT))
                        begin
                            status_c = fmc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // release: hand to the lock queue head, else free
                            if (lock_cnt_reg != '0)
                            begin
                                holder_next    = lock_rdata_reg;
                                lock_head_next = ptr_inc(lock_head_reg);
                                lock_cnt_next  = fmc_pkg::CNT_W'(lock_cnt_reg - 1'b1);
                                handed_c       = 1'b1;
                            end
                            else
                            begin
                                held_next   = 1'b0;
                                holder_next = '0;
                            end
                            if (func_reg == fmc_pkg::FN_CWAIT)
                            begin
                                cond_we        = 1'b1;
                                cond_tail_next = ptr_inc(cond_tail_reg);
                                cond_cnt_next  = fmc_pkg::CNT_W'(cond_cnt_reg + 1'b1);
                                status_c       = fmc_pkg::STAT_QUEUED;
                            end
                        end
                    end

                    fmc_pkg::FN_SIGNAL, fmc_pkg::FN_BCAST:
                    begin
                        woken_c = woken_reg;
                        if (cond_cnt_reg == '0)
                        begin
                            status_c = fmc_pkg::STAT_EMPTY;
                        end
                        else if (!wake_ok)
                        begin
                            status_c = fmc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            if (!held_reg)
                            begin
                                held_next   = 1'b1;
                                holder_next = cond_rdata_reg;
                            end
                            else if (holder_reg != cond_rdata_reg)
                            begin
                                lock_we        = 1'b1;
                                lock_wdata     = cond_rdata_reg;
                                lock_tail_next = ptr_inc(lock_tail_reg);
                                lock_cnt_next  = fmc_pkg::CNT_W'(lock_cnt_reg + 1'b1);
                            end
                            cond_head_next = ptr_inc(cond_head_reg);
                            cond_cnt_next  = fmc_pkg::CNT_W'(cond_cnt_reg - 1'b1);
                            woken_c        = fmc_pkg::WOKEN_W'(woken_reg + 1'b1);
                            woken_next     = woken_c;
                            // keep draining: pass through ST_BREAD for the next head read
                            if ((func_reg == fmc_pkg::FN_BCAST) &&
                                (cond_cnt_reg != fmc_pkg::CNT_W'(1)))
                            begin
                                finish     = 1'b0;
                                state_next = fmc_pkg::ST_BREAD;
                            end
                        end
                    end

                    default:
                    begin
                        status_c = fmc_pkg::STAT_OK;
                    end
                endcase

                if (finish)
                begin
                    res_next.status      = status_c;
                    res_next.owner_valid = held_next;
                    res_next.owner_id    = held_next ? holder_next : '0;
                    res_next.handed_over = handed_c;
                    res_next.woken_count = woken_c;
                    if (out_free)
                    begin
                        out_next       = res_next;
                        out_valid_next = 1'b1;
                        state_next     = fmc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = fmc_pkg::ST_DONE;
                    end
                end
            end

            fmc_pkg::ST_BREAD:
            begin
                state_next = fmc_pkg::ST_EXEC;
            end

            fmc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = fmc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmc_pkg::ST_IDLE;
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            lock_head_reg <= '0;
            lock_tail_reg <= '0;
            lock_cnt_reg  <= '0;
            cond_head_reg <= '0;
            cond_tail_reg <= '0;
            cond_cnt_reg  <= '0;
            woken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            holder_reg    <= holder_next;
            lock_head_reg <= lock_head_next;
            lock_tail_reg <= lock_tail_next;
            lock_cnt_reg  <= lock_cnt_next;
            cond_head_reg <= cond_head_next;
            cond_tail_reg <= cond_tail_next;
            cond_cnt_reg  <= cond_cnt_next;
            woken_reg     <= woken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= req.func;
            req_id_reg <= req.requester;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

### sim/tb_fifo_mutex_condvar_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_mutex_condvar_manager_top
// Self-checking bench for the mutex / condition variable lock manager. A
// shadow lock manager in the bench tracks holder and both wait queues and
// predicts every answer word. Directed calls cover the corner cases first.
// Queue fill calls then drive both wait queues to their limits. Random traffic
// with most releases aimed at the holder follows, with random idling on the
// request and answer channels in some phases.
// ----------------------------------------------------------------------------
module tb_fifo_mutex_condvar_manager_top;

    localparam logic [fmc_pkg::FUNC_W-1:0] FN_UNUSED6 = 3'd6;
    localparam logic [fmc_pkg::FUNC_W-1:0] FN_UNUSED7 = 3'd7;
    localparam int CLK_HALF    = 4;
    localparam int MAX_WAIT    = 13;
    localparam int TAIL_CYCLES = 2 * fmc_pkg::QUEUE_DEPTH + 2 * MAX_WAIT + 8;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    fmc_req_if req_ch ();
    fmc_rsp_if rsp_ch ();

    fifo_mutex_condvar_manager_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow lock manager
    logic                     mtx_held;
    logic [fmc_pkg::ID_W-1:0] mtx_holder;
    logic [fmc_pkg::ID_W-1:0] lock_wait_q[$];
    logic [fmc_pkg::ID_W-1:0] cond_wait_q[$];

    fmc_pkg::result_t answer_q[$];
    int               fail_count;
    int               cycle_count;
    bit               no_idle;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [fmc_pkg::ID_W-1:0] other_id(input logic [fmc_pkg::ID_W-1:0] id);
        return id + fmc_pkg::ID_W'($urandom_range(1, 15));
    endfunction

    // hand the mutex to the head lock waiter, or free it
    function automatic logic pass_mutex();
        if (lock_wait_q.size() != 0)
        begin
            mtx_holder = lock_wait_q.pop_front();
            return 1'b1;
        end
        mtx_held   = 1'b0;
        mtx_holder = '0;
        return 1'b0;
    endfunction

    // release the head condition waiter; it tries to lock at once
    function automatic logic wake_head();
        logic [fmc_pkg::ID_W-1:0] w;
        w = cond_wait_q[0];
        if (!mtx_held)
        begin
            mtx_held   = 1'b1;
            mtx_holder = w;
        end
        else if (mtx_holder != w)
        begin
            if (lock_wait_q.size() >= fmc_pkg::QUEUE_DEPTH)
                return 1'b0;
            lock_wait_q.push_back(w);
        end
        void'(cond_wait_q.pop_front());
        return 1'b1;
    endfunction

    function automatic fmc_pkg::result_t predict_answer(
        input logic [fmc_pkg::FUNC_W-1:0] fn,
        input logic [fmc_pkg::ID_W-1:0]   id);
        fmc_pkg::result_t r;
        logic             is_owner;
        r        = '0;
        r.status = fmc_pkg::STAT_OK;
        is_owner = mtx_held && (mtx_holder == id);
        case (fn)
            fmc_pkg::FN_LOCK, fmc_pkg::FN_TRYLOCK:
            begin
                if (!mtx_held)
                begin
                    mtx_held   = 1'b1;
                    mtx_holder = id;
                end
                else if (!is_owner)
                begin
                    if (fn == fmc_pkg::FN_TRYLOCK)
                        r.status = fmc_pkg::STAT_BUSY;
                    else if (lock_wait_q.size() >= fmc_pkg::QUEUE_DEPTH)
                        r.status = fmc_pkg::STAT_FULL;
                    else
                    begin
                        lock_wait_q.push_back(id);
                        r.status = fmc_pkg::STAT_QUEUED;
                    end
                end
            end
            fmc_pkg::FN_UNLOCK:
            begin
                if (!is_owner)
                    r.status = fmc_pkg::STAT_NOTOWNER;
                else
                    r.handed_over = pass_mutex();
            end
            fmc_pkg::FN_CWAIT:
            begin
                if (!is_owner)
                    r.status = fmc_pkg::STAT_NOTOWNER;
                else if (cond_wait_q.size() >= fmc_pkg::QUEUE_DEPTH)
                    r.status = fmc_pkg::STAT_FULL;
                else
                begin
                    r.handed_over = pass_mutex();
                    cond_wait_q.push_back(id);
                    r.status = fmc_pkg::STAT_QUEUED;
                end
            end
            fmc_pkg::FN_SIGNAL:
            begin
                if (cond_wait_q.size() == 0)
                    r.status = fmc_pkg::STAT_EMPTY;
                else if (wake_head())
                    r.woken_count = fmc_pkg::WOKEN_W'(1);
                else
                    r.status = fmc_pkg::STAT_FULL;
            end
            fmc_pkg::FN_BCAST:
            begin
                if (cond_wait_q.size() == 0)
                    r.status = fmc_pkg::STAT_EMPTY;
                else
                begin
                    while (cond_wait_q.size() != 0 && r.status == fmc_pkg::STAT_OK)
                    begin
                        if (wake_head())
                            r.woken_count = r.woken_count + 1'b1;
                        else
                            r.status = fmc_pkg::STAT_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.owner_valid = mtx_held;
        r.owner_id    = mtx_held ? mtx_holder : '0;
        return r;
    endfunction

    // send one request word; predict its answer at acceptance
    task automatic issue_call(input logic [fmc_pkg::FUNC_W-1:0] fn,
                              input logic [fmc_pkg::ID_W-1:0] id);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= fn;
        req_ch.requester <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        answer_q.push_back(predict_answer(fn, id));
    endtask

    // hold off the request channel until every answer is back
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(input string name, input int exp_v,
                                          input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
                     exp_v, act_v);
            fail_count++;
        end
    endfunction

    // answer channel: random stalls, check each accepted word
    initial
    begin
        int               hold_left;
        fmc_pkg::result_t exp_r;
        hold_left    = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: answer word with nothing expected, status %0d",
                             $time, rsp_ch.status);
                    fail_count++;
                end
                else
                begin
                    exp_r = answer_q.pop_front();
                    compare_field("status", int'(exp_r.status), int'(rsp_ch.status));
                    compare_field("owner_valid", int'(exp_r.owner_valid),
                                  int'(rsp_ch.owner_valid));
                    compare_field("owner_id", int'(exp_r.owner_id), int'(rsp_ch.owner_id));
                    compare_field("handed_over", int'(exp_r.handed_over),
                                  int'(rsp_ch.handed_over));
                    compare_field("woken_count", int'(exp_r.woken_count),
                                  int'(rsp_ch.woken_count));
                end
                hold_left = draw_wait();
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // calls on an idle manager, then the first grant
    task automatic test_reset_state();
        issue_call(fmc_pkg::FN_UNLOCK, 4'd0);
        issue_call(fmc_pkg::FN_CWAIT, 4'd15);
        issue_call(fmc_pkg::FN_SIGNAL, 4'd0);
        issue_call(fmc_pkg::FN_BCAST, 4'd15);
        issue_call(FN_UNUSED6, 4'd10);
        issue_call(FN_UNUSED7, 4'd5);
        issue_call(fmc_pkg::FN_TRYLOCK, 4'd5);
    endtask

    task automatic test_lock_paths();
        issue_call(fmc_pkg::FN_LOCK, 4'd5);      // recursive grant
        issue_call(fmc_pkg::FN_TRYLOCK, 4'd5);
        issue_call(fmc_pkg::FN_TRYLOCK, 4'd9);   // busy
        issue_call(fmc_pkg::FN_LOCK, 4'd9);
        issue_call(fmc_pkg::FN_LOCK, 4'd3);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd9);    // not owner
        issue_call(fmc_pkg::FN_CWAIT, 4'd9);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd5);    // hand to 9
        issue_call(fmc_pkg::FN_CWAIT, 4'd9);     // hand to 3
        issue_call(fmc_pkg::FN_CWAIT, 4'd3);     // frees the mutex
        issue_call(fmc_pkg::FN_SIGNAL, 4'd1);    // 9 takes the free mutex
        issue_call(fmc_pkg::FN_LOCK, 4'd12);
        issue_call(fmc_pkg::FN_BCAST, 4'd2);     // 3 joins the lock queue
        issue_call(fmc_pkg::FN_UNLOCK, 4'd9);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd12);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd3);
        // same id twice in the lock queue: handover to the caller itself
        issue_call(fmc_pkg::FN_LOCK, 4'd7);
        issue_call(fmc_pkg::FN_LOCK, 4'd2);
        issue_call(fmc_pkg::FN_LOCK, 4'd2);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd7);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd2);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd2);
        // woken waiter already holds the mutex: absorbed
        issue_call(fmc_pkg::FN_LOCK, 4'd4);
        issue_call(fmc_pkg::FN_CWAIT, 4'd4);
        issue_call(fmc_pkg::FN_LOCK, 4'd4);
        issue_call(fmc_pkg::FN_SIGNAL, 4'd4);
        issue_call(fmc_pkg::FN_UNLOCK, 4'd4);
    endtask

    task automatic test_queue_limits();
        logic [fmc_pkg::ID_W-1:0] id;
        // fill the condition queue through lock / cond-wait pairs
        while (cond_wait_q.size() < fmc_pkg::QUEUE_DEPTH)
        begin
            if (mtx_held)
                issue_call(fmc_pkg::FN_CWAIT, mtx_holder);
            else
                issue_call(fmc_pkg::FN_LOCK, fmc_pkg::ID_W'($urandom_range(1, 15)));
        end
        if (!mtx_held)
            issue_call(fmc_pkg::FN_LOCK, 4'd0);
        // fill the lock queue, then overflow it
        while (lock_wait_q.size() < fmc_pkg::QUEUE_DEPTH)
            issue_call(fmc_pkg::FN_LOCK, other_id(mtx_holder));
        issue_call(fmc_pkg::FN_LOCK, other_id(mtx_holder));
        issue_call(fmc_pkg::FN_CWAIT, mtx_holder);
        // woken waiters find the lock queue full
        issue_call(fmc_pkg::FN_SIGNAL, 4'd8);
        issue_call(fmc_pkg::FN_BCAST, 4'd8);
        issue_call(fmc_pkg::FN_UNLOCK, mtx_holder);
        issue_call(fmc_pkg::FN_UNLOCK, mtx_holder);
        issue_call(fmc_pkg::FN_BCAST, 4'd1);
        wait_all_answered();
        // drain what is left
        while (mtx_held || cond_wait_q.size() != 0)
        begin
            if (mtx_held)
                issue_call(fmc_pkg::FN_UNLOCK, mtx_holder);
            else
                issue_call(fmc_pkg::FN_BCAST, 4'd0);
        end
        id = fmc_pkg::ID_W'($urandom_range(0, 15));
        issue_call(fmc_pkg::FN_SIGNAL, id);
    endtask

    task automatic test_random_traffic(input int n_calls);
        int                         pick;
        logic [fmc_pkg::FUNC_W-1:0] fn;
        logic [fmc_pkg::ID_W-1:0]   id;
        for (int i = 0; i < n_calls; i++)
        begin
            pick = $urandom_range(0, 99);
            id   = fmc_pkg::ID_W'($urandom_range(0, 15));
            if (pick < 22)
                fn = fmc_pkg::FN_LOCK;
            else if (pick < 30)
                fn = fmc_pkg::FN_TRYLOCK;
            else if (pick < 55)
                fn = fmc_pkg::FN_UNLOCK;
            else if (pick < 70)
                fn = fmc_pkg::FN_CWAIT;
            else if (pick < 82)
                fn = fmc_pkg::FN_SIGNAL;
            else if (pick < 90)
                fn = fmc_pkg::FN_BCAST;
            else if (pick < 93)
                fn = pick[0] ? FN_UNUSED6 : FN_UNUSED7;
            else
                fn = fmc_pkg::FUNC_W'($urandom_range(0, 7));
            // aim most releases at the holder so ownership keeps moving
            if ((fn == fmc_pkg::FN_UNLOCK || fn == fmc_pkg::FN_CWAIT) && mtx_held &&
                $urandom_range(0, 4) != 0)
                id = mtx_holder;
            issue_call(fn, id);
        end
    endtask

    initial
    begin
        fail_count       = 0;
        no_idle          = 1'b0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= fmc_pkg::FN_LOCK;
        req_ch.requester <= '0;
        mtx_held         = 1'b0;
        mtx_holder       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_lock_paths();
        test_queue_limits();
        test_random_traffic(80);
        no_idle = 1'b1;
        test_random_traffic(80);
        no_idle = 1'b0;
        wait_all_answered();
        test_random_traffic(80);
        no_idle = 1'b1;
        test_random_traffic(60);
        no_idle = 1'b0;
        test_random_traffic(80);

        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && answer_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/fmc_pkg.sv
design/fmc_if.sv
design/fifo_mutex_condvar_manager_top.sv
sim/tb_fifo_mutex_condvar_manager_top.sv
